// ===== sv/line_segment_rect_clipper_defines.svh =====
// Assertion macros used by the clipper's top-level RTL file.
`ifndef LINE_SEGMENT_RECT_CLIPPER_DEFINES_SVH
`define LINE_SEGMENT_RECT_CLIPPER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LSRC_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LSRC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lsrc_pkg.sv =====
// Shared types, constants and helper functions of the line segment clipper.
`default_nettype none
package lsrc_pkg;

    localparam int COORD_WIDTH = 16;
    // Magnitudes of coordinate differences need one bit more than a coordinate.
    localparam int MW          = COORD_WIDTH + 1;
    // The crossing quotient never exceeds the magnitude of the numerator factor.
    localparam int QW          = MW;
    localparam int PW          = 2 * MW;
    localparam int VW          = QW + 2;
    localparam int LANES       = 4;
    // Front stage, multiply stage, one cell per quotient bit, fix-up stage, output stage.
    localparam int PIPE_DEPTH  = QW + 4;
    localparam int OCC_W       = $clog2(PIPE_DEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COORD_WIDTH:0]   diff_t;
    typedef logic [MW-1:0]                 mag_t;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_BOTTOM = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_ACCEPT,
        MODE_REJECT,
        MODE_HORZ,
        MODE_VERT,
        MODE_GENERAL
    } mode_t;

    localparam coord_t CLIP_LEFT_RST   = coord_t'(0);
    localparam coord_t CLIP_TOP_RST    = coord_t'(0);
    localparam coord_t CLIP_RIGHT_RST  = coord_t'(1023);
    localparam coord_t CLIP_BOTTOM_RST = coord_t'(767);

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } clip_t;

    // Segment data that travels alongside the crossing lanes.
    typedef struct packed {
        coord_t     x1;
        coord_t     y1;
        coord_t     x2;
        coord_t     y2;
        mode_t      mode;
        logic [1:0] x_hit;
        logic [1:0] y_hit;
        coord_t     xe0;
        coord_t     xe1;
        coord_t     ye0;
        coord_t     ye1;
    } seg_t;

    typedef struct packed {
        logic   neg;
        coord_t base;
        mag_t   amag;
        mag_t   bmag;
        mag_t   dmag;
    } lane_in_t;

    typedef struct packed {
        logic          neg;
        coord_t        base;
        mag_t          dmag;
        mag_t          rem;
        logic [QW-1:0] low;
    } lane_div_t;

    typedef lane_in_t  [LANES-1:0] lane_in_vec_t;
    typedef lane_div_t [LANES-1:0] lane_div_vec_t;
    typedef coord_t    [LANES-1:0] cross_vec_t;

    function automatic logic [3:0] outcode(coord_t x, coord_t y, clip_t c);
        coord_t     l;
        coord_t     t;
        coord_t     r;
        coord_t     b;
        logic [3:0] code;
        l = c.left;
        t = c.top;
        r = c.right;
        b = c.bottom;
        code[0] = (x < l);
        code[1] = (x > r);
        code[2] = (y < t);
        code[3] = (y > b);
        return code;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lsrc_in_if.sv =====
// Segment input channel: valid, ready and the two end points.
`default_nettype none
interface lsrc_in_if import lsrc_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

// ===== sv/lsrc_out_if.sv =====
// Result output channel: valid, ready, visibility and the clipped end points.
`default_nettype none
interface lsrc_out_if import lsrc_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   visible;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;

    modport source (output valid, visible, clipped_start_x, clipped_start_y,
                    clipped_end_x, clipped_end_y, input ready);
    modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                    clipped_end_x, clipped_end_y, output ready);
endinterface
`default_nettype wire

// ===== sv/lsrc_front.sv =====
// Front stage: outcodes, case selection, edge choice and crossing lane setup.
`default_nettype none
module lsrc_front import lsrc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire clip_t clip,
    lsrc_in_if.sink    seg,
    output logic       dn_valid,
    input  wire logic  dn_ready,
    output seg_t       dn_seg,
    output lane_in_vec_t dn_lanes
);

    logic         valid_reg;
    seg_t         seg_reg;
    seg_t         seg_next;
    lane_in_vec_t lanes_reg;
    lane_in_vec_t lanes_next;

    function automatic mag_t mag(diff_t v);
        diff_t n;
        n = -v;
        return v[COORD_WIDTH] ? mag_t'(n) : mag_t'(v);
    endfunction

    function automatic lane_in_t setup(coord_t base, diff_t a, diff_t b, diff_t d);
        lane_in_t s;
        s.neg  = ((a < 0) ^ (b < 0) ^ (d < 0)) && (a != 0) && (b != 0);
        s.base = base;
        s.amag = mag(a);
        s.bmag = mag(b);
        s.dmag = mag(d);
        return s;
    endfunction

    always_comb
    begin
        coord_t     x1;
        coord_t     y1;
        coord_t     x2;
        coord_t     y2;
        coord_t     l;
        coord_t     t;
        coord_t     r;
        coord_t     b;
        logic [3:0] c1;
        logic [3:0] c2;
        diff_t      dx;
        diff_t      dy;
        x1 = seg.start_x;
        y1 = seg.start_y;
        x2 = seg.end_x;
        y2 = seg.end_y;
        l  = clip.left;
        t  = clip.top;
        r  = clip.right;
        b  = clip.bottom;
        c1 = outcode(x1, y1, clip);
        c2 = outcode(x2, y2, clip);
        dx = diff_t'(x2) - diff_t'(x1);
        dy = diff_t'(y2) - diff_t'(y1);

        seg_next.x1 = x1;
        seg_next.y1 = y1;
        seg_next.x2 = x2;
        seg_next.y2 = y2;

        if ((c1 | c2) == 4'b0000)
            seg_next.mode = MODE_ACCEPT;
        else if ((c1 & c2) != 4'b0000)
            seg_next.mode = MODE_REJECT;
        else if (y1 == y2)
            seg_next.mode = MODE_HORZ;
        else if (x1 == x2)
            seg_next.mode = MODE_VERT;
        else
            seg_next.mode = MODE_GENERAL;

        // Vertical edge crossings for each end point.
        seg_next.x_hit[0] = 1'b0;
        seg_next.xe0      = l;
        if (x1 < l && x2 >= l)
        begin
            seg_next.x_hit[0] = 1'b1;
        end
        else if (x1 > r && x2 <= r)
        begin
            seg_next.x_hit[0] = 1'b1;
            seg_next.xe0      = r;
        end
        seg_next.x_hit[1] = 1'b0;
        seg_next.xe1      = l;
        if (x2 < l && x1 >= l)
        begin
            seg_next.x_hit[1] = 1'b1;
        end
        else if (x2 > r && x1 <= r)
        begin
            seg_next.x_hit[1] = 1'b1;
            seg_next.xe1      = r;
        end

        // Horizontal edge crossings for each end point.
        seg_next.y_hit[0] = 1'b0;
        seg_next.ye0      = t;
        if (y1 < t && y2 >= t)
        begin
            seg_next.y_hit[0] = 1'b1;
        end
        else if (y1 > b && y2 <= b)
        begin
            seg_next.y_hit[0] = 1'b1;
            seg_next.ye0      = b;
        end
        seg_next.y_hit[1] = 1'b0;
        seg_next.ye1      = t;
        if (y2 < t && y1 >= t)
        begin
            seg_next.y_hit[1] = 1'b1;
        end
        else if (y2 > b && y1 <= b)
        begin
            seg_next.y_hit[1] = 1'b1;
            seg_next.ye1      = b;
        end

        // All crossings are measured from the first end point.
        lanes_next[0] = setup(y1, dy, diff_t'(seg_next.xe0) - diff_t'(x1), dx);
        lanes_next[1] = setup(y1, dy, diff_t'(seg_next.xe1) - diff_t'(x1), dx);
        lanes_next[2] = setup(x1, dx, diff_t'(seg_next.ye0) - diff_t'(y1), dy);
        lanes_next[3] = setup(x1, dx, diff_t'(seg_next.ye1) - diff_t'(y1), dy);
    end

    assign seg.ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (seg.ready)
            valid_reg <= seg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (seg.ready && seg.valid)
        begin
            seg_reg   <= seg_next;
            lanes_reg <= lanes_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_seg   = seg_reg;
    assign dn_lanes = lanes_reg;

endmodule
`default_nettype wire

// ===== sv/lsrc_mul.sv =====
// Multiply stage: forms each lane's numerator and splits it for the divider cells.
`default_nettype none
module lsrc_mul import lsrc_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire seg_t          up_seg,
    input  wire lane_in_vec_t  up_lanes,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output seg_t               dn_seg,
    output lane_div_vec_t      dn_lanes
);

    logic          valid_reg;
    seg_t          seg_reg;
    lane_div_vec_t lanes_reg;
    lane_div_vec_t lanes_next;

    always_comb
    begin
        logic [PW-1:0] prod;
        for (int i = 0; i < LANES; i++)
        begin
            prod = PW'(up_lanes[i].amag) * PW'(up_lanes[i].bmag);
            lanes_next[i].neg  = up_lanes[i].neg;
            lanes_next[i].base = up_lanes[i].base;
            lanes_next[i].dmag = up_lanes[i].dmag;
            // The upper part is already below the divisor when the crossing is used.
            lanes_next[i].rem  = prod[PW-1:QW];
            lanes_next[i].low  = prod[QW-1:0];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            seg_reg   <= up_seg;
            lanes_reg <= lanes_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_seg   = seg_reg;
    assign dn_lanes = lanes_reg;

endmodule
`default_nettype wire

// ===== sv/lsrc_div_cell.sv =====
// Divider cell: one restoring quotient bit for every crossing lane.
`default_nettype none
module lsrc_div_cell import lsrc_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire seg_t          up_seg,
    input  wire lane_div_vec_t up_lanes,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output seg_t               dn_seg,
    output lane_div_vec_t      dn_lanes
);

    logic          valid_reg;
    seg_t          seg_reg;
    lane_div_vec_t lanes_reg;
    lane_div_vec_t lanes_next;

    always_comb
    begin
        logic [MW:0] trial;
        logic [MW:0] diff;
        logic        ge;
        for (int i = 0; i < LANES; i++)
        begin
            trial = {up_lanes[i].rem, up_lanes[i].low[QW-1]};
            diff  = trial - {1'b0, up_lanes[i].dmag};
            ge    = (trial >= {1'b0, up_lanes[i].dmag});
            lanes_next[i].neg  = up_lanes[i].neg;
            lanes_next[i].base = up_lanes[i].base;
            lanes_next[i].dmag = up_lanes[i].dmag;
            lanes_next[i].rem  = ge ? diff[MW-1:0] : trial[MW-1:0];
            // Dividend bits leave at the top while quotient bits enter at the bottom.
            lanes_next[i].low  = {up_lanes[i].low[QW-2:0], ge};
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            seg_reg   <= up_seg;
            lanes_reg <= lanes_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_seg   = seg_reg;
    assign dn_lanes = lanes_reg;

endmodule
`default_nettype wire

// ===== sv/lsrc_back.sv =====
// Back end: signed crossing fix-up, end point selection, visibility and output register.
`default_nettype none
module lsrc_back import lsrc_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire clip_t         clip,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire seg_t          up_seg,
    input  wire lane_div_vec_t up_lanes,
    lsrc_out_if.source         res
);

    logic       fix_valid_reg;
    logic       fix_ready;
    seg_t       fix_seg_reg;
    cross_vec_t cross_reg;
    cross_vec_t cross_next;

    logic       out_valid_reg;
    logic       vis_reg;
    logic       vis_next;
    coord_t     sx_reg;
    coord_t     sy_reg;
    coord_t     ex_reg;
    coord_t     ey_reg;
    coord_t     sx_next;
    coord_t     sy_next;
    coord_t     ex_next;
    coord_t     ey_next;

    function automatic coord_t clamp(coord_t v, coord_t lo, coord_t hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Base plus signed quotient, truncated toward zero as a whole.
    always_comb
    begin
        logic signed [VW-1:0] q;
        logic signed [VW-1:0] v0;
        logic signed [VW-1:0] v;
        for (int i = 0; i < LANES; i++)
        begin
            q  = $signed({2'b00, up_lanes[i].low});
            if (up_lanes[i].neg)
                q = -q;
            v0 = VW'(up_lanes[i].base) + q;
            v  = v0;
            if (up_lanes[i].rem != '0)
            begin
                if (up_lanes[i].neg)
                begin
                    if (v0 > 0)
                        v = v0 - 1;
                end
                else if (v0 < 0)
                begin
                    v = v0 + 1;
                end
            end
            cross_next[i] = v[COORD_WIDTH-1:0];
        end
    end

    always_comb
    begin
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
        x1 = fix_seg_reg.x1;
        y1 = fix_seg_reg.y1;
        x2 = fix_seg_reg.x2;
        y2 = fix_seg_reg.y2;
        l  = clip.left;
        t  = clip.top;
        r  = clip.right;
        b  = clip.bottom;
        sx_next = x1;
        sy_next = y1;
        ex_next = x2;
        ey_next = y2;
        case (fix_seg_reg.mode)
            MODE_HORZ:
            begin
                sx_next = clamp(x1, l, r);
                ex_next = clamp(x2, l, r);
            end
            MODE_VERT:
            begin
                sy_next = clamp(y1, t, b);
                ey_next = clamp(y2, t, b);
            end
            MODE_GENERAL:
            begin
                if (fix_seg_reg.x_hit[0])
                begin
                    sx_next = fix_seg_reg.xe0;
                    sy_next = cross_reg[0];
                end
                if (fix_seg_reg.y_hit[0])
                begin
                    sy_next = fix_seg_reg.ye0;
                    sx_next = cross_reg[2];
                end
                if (fix_seg_reg.x_hit[1])
                begin
                    ex_next = fix_seg_reg.xe1;
                    ey_next = cross_reg[1];
                end
                if (fix_seg_reg.y_hit[1])
                begin
                    ey_next = fix_seg_reg.ye1;
                    ex_next = cross_reg[3];
                end
            end
            default:
            begin
                sx_next = x1;
            end
        endcase
        case (fix_seg_reg.mode)
            MODE_ACCEPT: vis_next = 1'b1;
            MODE_REJECT: vis_next = 1'b0;
            default:     vis_next = (outcode(sx_next, sy_next, clip) == 4'b0000) &&
                                    (outcode(ex_next, ey_next, clip) == 4'b0000);
        endcase
    end

    assign fix_ready = !out_valid_reg || res.ready;
    assign up_ready  = !fix_valid_reg || fix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
                fix_valid_reg <= up_valid;
            if (fix_ready)
                out_valid_reg <= fix_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            fix_seg_reg <= up_seg;
            cross_reg   <= cross_next;
        end
        if (fix_ready && fix_valid_reg)
        begin
            vis_reg <= vis_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            ex_reg  <= ex_next;
            ey_reg  <= ey_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.visible         = vis_reg;
    assign res.clipped_start_x = sx_reg;
    assign res.clipped_start_y = sy_reg;
    assign res.clipped_end_x   = ex_reg;
    assign res.clipped_end_y   = ey_reg;

endmodule
`default_nettype wire

// ===== sv/line_segment_rect_clipper.sv =====
// Top level of the line segment clipper against a configurable clip rectangle.
// Path: a segment passes the front stage, the multiply stage, the chain of COORD_WIDTH + 1
// divider cells, the fix-up stage and the output register.
// Throughput: one segment per cycle while the sink takes results; every stage holds its own
// transaction and advances whenever the stage after it is empty or moving.
// Reset: rst_n clears all stage valid flags and loads the clip rectangle (0, 0)-(1023, 767).
`default_nettype none
`include "line_segment_rect_clipper_defines.svh"
module line_segment_rect_clipper import lsrc_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire coord_t     cfg_data,
    lsrc_in_if.sink         seg,
    lsrc_out_if.source      res
);

    // The clip rectangle. Writes are only expected while no transaction is in flight,
    // so the front stage and the back end read it directly rather than carrying a copy.
    clip_t clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.left   <= CLIP_LEFT_RST;
            clip_reg.top    <= CLIP_TOP_RST;
            clip_reg.right  <= CLIP_RIGHT_RST;
            clip_reg.bottom <= CLIP_BOTTOM_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_LEFT:   clip_reg.left   <= cfg_data;
                REG_TOP:    clip_reg.top    <= cfg_data;
                REG_RIGHT:  clip_reg.right  <= cfg_data;
                REG_BOTTOM: clip_reg.bottom <= cfg_data;
                default:    clip_reg.left   <= clip_reg.left;
            endcase
        end
    end

    // The front stage classifies the segment (trivial accept, trivial reject,
    // horizontal, vertical or general) and prepares four crossing lanes: the
    // crossings of the first and second end point with a vertical edge and with
    // a horizontal edge. Each lane is base + a * b / d, truncated toward zero.
    logic          front_valid;
    logic          front_ready;
    seg_t          front_seg;
    lane_in_vec_t  front_lanes;

    lsrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .clip     (clip_reg),
        .seg      (seg),
        .dn_valid (front_valid),
        .dn_ready (front_ready),
        .dn_seg   (front_seg),
        .dn_lanes (front_lanes)
    );

    // Chain links: index 0 is the multiply stage output, index QW the divider output.
    logic          link_valid [QW+1];
    logic          link_ready [QW+1];
    seg_t          link_seg   [QW+1];
    lane_div_vec_t link_lanes [QW+1];

    lsrc_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_ready (front_ready),
        .up_seg   (front_seg),
        .up_lanes (front_lanes),
        .dn_valid (link_valid[0]),
        .dn_ready (link_ready[0]),
        .dn_seg   (link_seg[0]),
        .dn_lanes (link_lanes[0])
    );

    // One cell per quotient bit. Each cell passes the segment along and shifts
    // one more quotient bit into every lane.
    for (genvar g = 0; g < QW; g++)
    begin : g_div
        lsrc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[g]),
            .up_ready (link_ready[g]),
            .up_seg   (link_seg[g]),
            .up_lanes (link_lanes[g]),
            .dn_valid (link_valid[g+1]),
            .dn_ready (link_ready[g+1]),
            .dn_seg   (link_seg[g+1]),
            .dn_lanes (link_lanes[g+1])
        );
    end

    // The back end turns each quotient into a signed crossing truncated toward
    // zero, picks the end points for the segment's case and holds the result
    // in the output register until the sink takes it.
    lsrc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .clip     (clip_reg),
        .up_valid (link_valid[QW]),
        .up_ready (link_ready[QW]),
        .up_seg   (link_seg[QW]),
        .up_lanes (link_lanes[QW]),
        .res      (res)
    );

    // Count of transactions in flight, kept for the checks below.
    logic             in_acc;
    logic             out_acc;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    assign in_acc  = seg.valid && seg.ready;
    assign out_acc = res.valid && res.ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_acc && !out_acc)
            occ_next = occ_reg + OCC_W'(1);
        else if (out_acc && !in_acc)
            occ_next = occ_reg - OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    `LSRC_ASSERT_IMPLY(a_occ_bound, 1'b1, occ_reg <= OCC_W'(PIPE_DEPTH), "too many in flight")
    `LSRC_ASSERT_NEXT(a_no_phantom, (occ_reg == '0) && !in_acc, !res.valid, "phantom result")
    `LSRC_ASSERT_IMPLY(a_ready_chain, !res.valid, seg.ready, "input stalled with empty output")

endmodule
`default_nettype wire
